@@ rtl/mmt_pkg.sv @@
// Shared constants, register indexes and the saturation helper for the
// Mandelbrot membership test. No dependencies.
`timescale 1ns / 1ps

package mmt_pkg;

  localparam int WORD_BITS  = 32;
  localparam int FRAC_BITS  = 28;
  localparam int ITER_BITS  = 16;
  localparam int COORD_BITS = 12;
  localparam int DIM_BITS   = 13;
  localparam int SCALE_BITS = WORD_BITS - 1;

  localparam int PROD_BITS   = 2 * WORD_BITS;
  localparam int NUM_BITS    = SCALE_BITS + COORD_BITS + DIM_BITS;
  localparam int CAP_BITS    = WORD_BITS + 2;
  localparam int SAT_IN_BITS = PROD_BITS - FRAC_BITS + 2;
  localparam int DIV_CNT_BITS = $clog2(NUM_BITS + 1);

  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = WORD_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ITER  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_RE = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_IM = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RES_X     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RES_Y     = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SIZE_X    = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SIZE_Y    = 3'd7;

  localparam logic [ITER_BITS-1:0]  RST_MAX_ITER = ITER_BITS'(64);
  localparam logic [SCALE_BITS-1:0] RST_SCALE    = SCALE_BITS'(1073742);
  localparam logic [DIM_BITS-1:0]   RST_RES_X    = DIM_BITS'(800);
  localparam logic [DIM_BITS-1:0]   RST_RES_Y    = DIM_BITS'(600);
  localparam logic [DIM_BITS-1:0]   RST_SIZE_X   = DIM_BITS'(800);
  localparam logic [DIM_BITS-1:0]   RST_SIZE_Y   = DIM_BITS'(600);

  localparam logic [NUM_BITS-1:0]  MAP_CAP_NUM = NUM_BITS'(1) << (WORD_BITS + 1);
  localparam logic [CAP_BITS-1:0]  MAP_CAP     = CAP_BITS'(1) << (WORD_BITS + 1);
  localparam logic [PROD_BITS:0]   ESCAPE_FOUR = (PROD_BITS + 1)'(4) << (2 * FRAC_BITS);

  localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // Clamps a wide signed value to the fixed-point word range.
  function automatic logic signed [WORD_BITS-1:0] sat_word(
      input logic signed [SAT_IN_BITS-1:0] v);
    logic [SAT_IN_BITS-WORD_BITS:0] hi;
    hi = v[SAT_IN_BITS-1:WORD_BITS-1];
    if (hi == '0 || hi == '1) begin
      return v[WORD_BITS-1:0];
    end else if (v[SAT_IN_BITS-1]) begin
      return WORD_MIN;
    end else begin
      return WORD_MAX;
    end
  endfunction

endpackage

@@ rtl/mandelbrot_membership_test.sv @@
// Top level of the Mandelbrot membership test: configuration registers,
// sequencer and the shared multiplier. Depends on mmt_pkg and mmt_div.
`timescale 1ns / 1ps

// A point is taken when start is high while busy is low, and busy stays high
// until the answer appears on in_set with done high for one cycle; that word
// must be captured then. Each axis is mapped with two products on the shared
// 32 by 32 multiplier and a divide that yields one quotient bit per cycle.
// Every pass of z = z*z + c then steps through S_SQR, S_SQI, S_CROSS and
// S_UPD, three products through the same multiplier plus the test and
// update. A point makes n passes, with n at most max_iterations (64 after
// reset) and one pass when the limit is zero.
module mandelbrot_membership_test (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [mmt_pkg::COORD_BITS-1:0]    point_x,
  input  logic [mmt_pkg::COORD_BITS-1:0]    point_y,
  output logic                              done,
  output logic                              in_set,
  input  logic                              wr_en,
  input  logic [mmt_pkg::CFG_IDX_BITS-1:0]  wr_index,
  input  logic [mmt_pkg::CFG_DATA_BITS-1:0] wr_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_MAP_PR, S_MAP_SC, S_DIV_GO, S_DIV_WAIT,
    S_SQR, S_SQI, S_CROSS, S_UPD
  } state_t;

  localparam int W  = mmt_pkg::WORD_BITS;
  localparam int P  = mmt_pkg::PROD_BITS;
  localparam int F  = mmt_pkg::FRAC_BITS;
  localparam int SB = mmt_pkg::SAT_IN_BITS;

  state_t state;

  logic [mmt_pkg::ITER_BITS-1:0]  max_iterations;
  logic [mmt_pkg::SCALE_BITS-1:0] view_scale;
  logic signed [W-1:0]            center_re;
  logic signed [W-1:0]            center_im;
  logic [mmt_pkg::DIM_BITS-1:0]   resolution_x;
  logic [mmt_pkg::DIM_BITS-1:0]   resolution_y;
  logic [mmt_pkg::DIM_BITS-1:0]   size_x;
  logic [mmt_pkg::DIM_BITS-1:0]   size_y;

  logic [mmt_pkg::COORD_BITS-1:0] px;
  logic [mmt_pkg::COORD_BITS-1:0] py;
  logic                           axis;
  logic signed [W-1:0]            cr;
  logic signed [W-1:0]            ci;
  logic signed [W-1:0]            zr;
  logic signed [W-1:0]            zi;
  logic [P-1:0]                   sr;
  logic [P-1:0]                   si;
  logic [mmt_pkg::ITER_BITS-1:0]  count;

  logic signed [W-1:0] mul_a;
  logic signed [W-1:0] mul_b;
  logic signed [P-1:0] prod;

  logic                           div_start;
  logic                           div_done;
  logic [mmt_pkg::NUM_BITS-1:0]   div_quot;
  logic [mmt_pkg::DIM_BITS-1:0]   div_den;
  logic [mmt_pkg::DIM_BITS-1:0]   size_sel;
  logic [mmt_pkg::DIM_BITS-1:0]   res_sel;
  logic [mmt_pkg::COORD_BITS-1:0] point_sel;
  logic signed [W-1:0]            center_sel;

  logic [mmt_pkg::CAP_BITS-1:0] q_cap;
  logic signed [SB-1:0]         map_diff;
  logic signed [W-1:0]          map_c;

  logic [P:0]                    sq_sum;
  logic                          escape;
  logic [mmt_pkg::ITER_BITS:0]   count_n;
  logic [mmt_pkg::ITER_BITS:0]   limit;
  logic signed [SB-1:0]          nr;
  logic signed [SB-1:0]          ni;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= mmt_pkg::RST_MAX_ITER;
      view_scale     <= mmt_pkg::RST_SCALE;
      center_re      <= '0;
      center_im      <= '0;
      resolution_x   <= mmt_pkg::RST_RES_X;
      resolution_y   <= mmt_pkg::RST_RES_Y;
      size_x         <= mmt_pkg::RST_SIZE_X;
      size_y         <= mmt_pkg::RST_SIZE_Y;
    end else if (wr_en) begin
      unique case (wr_index)
        mmt_pkg::CFG_MAX_ITER:  max_iterations <= wr_data[mmt_pkg::ITER_BITS-1:0];
        mmt_pkg::CFG_SCALE:     view_scale     <= wr_data[mmt_pkg::SCALE_BITS-1:0];
        mmt_pkg::CFG_CENTER_RE: center_re      <= wr_data[W-1:0];
        mmt_pkg::CFG_CENTER_IM: center_im      <= wr_data[W-1:0];
        mmt_pkg::CFG_RES_X:     resolution_x   <= wr_data[mmt_pkg::DIM_BITS-1:0];
        mmt_pkg::CFG_RES_Y:     resolution_y   <= wr_data[mmt_pkg::DIM_BITS-1:0];
        mmt_pkg::CFG_SIZE_X:    size_x         <= wr_data[mmt_pkg::DIM_BITS-1:0];
        mmt_pkg::CFG_SIZE_Y:    size_y         <= wr_data[mmt_pkg::DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign point_sel  = axis ? py : px;
  assign res_sel    = axis ? resolution_y : resolution_x;
  assign size_sel   = axis ? size_y : size_x;
  assign center_sel = axis ? center_im : center_re;
  assign div_den    = (size_sel == '0) ? mmt_pkg::DIM_BITS'(1) : size_sel;
  assign div_start  = (state == S_DIV_GO);

  always_comb begin
    unique case (state)
      S_MAP_PR: begin
        mul_a = $signed({{(W-mmt_pkg::COORD_BITS){1'b0}}, point_sel});
        mul_b = $signed({{(W-mmt_pkg::DIM_BITS){1'b0}}, res_sel});
      end
      S_MAP_SC: begin
        mul_a = $signed({1'b0, view_scale});
        mul_b = prod[W-1:0];
      end
      S_SQR: begin
        mul_a = zr;
        mul_b = zr;
      end
      S_SQI: begin
        mul_a = zi;
        mul_b = zi;
      end
      default: begin
        mul_a = zr;
        mul_b = zi;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  mmt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (prod[mmt_pkg::NUM_BITS-1:0]),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign q_cap = (div_quot > mmt_pkg::MAP_CAP_NUM) ? mmt_pkg::MAP_CAP
                                                   : div_quot[mmt_pkg::CAP_BITS-1:0];
  assign map_diff = $signed({{(SB-mmt_pkg::CAP_BITS){1'b0}}, q_cap})
                  - $signed({{(SB-W){center_sel[W-1]}}, center_sel});
  assign map_c = mmt_pkg::sat_word(map_diff);

  assign sq_sum  = {1'b0, sr} + {1'b0, si};
  assign escape  = (sq_sum >= mmt_pkg::ESCAPE_FOUR);
  assign count_n = {1'b0, count} + 1'b1;
  assign limit   = {1'b0, max_iterations};
  assign nr = $signed({2'b00, sr[P-1:F]}) - $signed({2'b00, si[P-1:F]})
            + $signed({{(SB-W){cr[W-1]}}, cr});
  assign ni = $signed({prod[P-1], prod[P-1:F-1]})
            + $signed({{(SB-W){ci[W-1]}}, ci});

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      in_set <= 1'b0;
      axis   <= 1'b0;
      count  <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            px    <= point_x;
            py    <= point_y;
            axis  <= 1'b0;
            state <= S_MAP_PR;
          end
        end
        S_MAP_PR: state <= S_MAP_SC;
        S_MAP_SC: state <= S_DIV_GO;
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            if (!axis) begin
              cr    <= map_c;
              axis  <= 1'b1;
              state <= S_MAP_PR;
            end else begin
              ci    <= map_c;
              zr    <= '0;
              zi    <= '0;
              count <= '0;
              state <= S_SQR;
            end
          end
        end
        S_SQR: state <= S_SQI;
        S_SQI: begin
          sr    <= prod;
          state <= S_CROSS;
        end
        S_CROSS: begin
          si    <= prod;
          state <= S_UPD;
        end
        S_UPD: begin
          priority if (escape) begin
            done   <= 1'b1;
            in_set <= (count == max_iterations);
            state  <= S_IDLE;
          end else if (count_n >= limit) begin
            done   <= 1'b1;
            in_set <= (count_n == limit);
            state  <= S_IDLE;
          end else begin
            zr    <= mmt_pkg::sat_word(nr);
            zi    <= mmt_pkg::sat_word(ni);
            count <= count_n[mmt_pkg::ITER_BITS-1:0];
            state <= S_SQR;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/mmt_div.sv @@
// Restoring divider, one quotient bit per cycle, for the coordinate mapping.
// Depends on mmt_pkg.
`timescale 1ns / 1ps

module mmt_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [mmt_pkg::NUM_BITS-1:0] num,
  input  logic [mmt_pkg::DIM_BITS-1:0] den,
  output logic                         done,
  output logic [mmt_pkg::NUM_BITS-1:0] quot
);

  logic                             running;
  logic [mmt_pkg::DIV_CNT_BITS-1:0] cnt;
  logic [mmt_pkg::DIM_BITS-1:0]     rem;
  logic [mmt_pkg::DIM_BITS:0]       trial;
  logic                             fits;

  assign trial = {rem, quot[mmt_pkg::NUM_BITS-1]};
  assign fits  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= mmt_pkg::DIV_CNT_BITS'(mmt_pkg::NUM_BITS);
        rem     <= '0;
        quot    <= num;
      end else if (running) begin
        if (fits) begin
          rem <= mmt_pkg::DIM_BITS'(trial - {1'b0, den});
        end else begin
          rem <= trial[mmt_pkg::DIM_BITS-1:0];
        end
        quot <= {quot[mmt_pkg::NUM_BITS-2:0], fits};
        cnt  <= cnt - 1'b1;
        if (cnt == mmt_pkg::DIV_CNT_BITS'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for mandelbrot_membership_test: random and directed
// screen points against a bit-exact predictor of the escape-time answer.
// Depends on mmt_pkg and the block under test; needs nothing else.
`timescale 1ns / 1ps

module tb_top;
  import mmt_pkg::*;

  localparam int unsigned STALL_LIMIT = 1_100_000;
  localparam int unsigned REPORT_CAP = 50;
  localparam longint WORD_TOP = (longint'(1) << (WORD_BITS - 1)) - 1;
  localparam bit [63:0] ESCAPE_LIMIT = 64'd4 << (2 * FRAC_BITS);

  typedef struct {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    bit hold;
  } point_t;

  typedef struct {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    bit in_set;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [COORD_BITS-1:0] point_x = '0;
  logic [COORD_BITS-1:0] point_y = '0;
  logic done;
  logic in_set;
  logic wr_en = 1'b0;
  logic [CFG_IDX_BITS-1:0] wr_index = '0;
  logic [CFG_DATA_BITS-1:0] wr_data = '0;

  // Mirror of the register file, at the widths the block keeps (the centers as longint).
  logic [ITER_BITS-1:0] iter_limit = 16'd64;
  logic [SCALE_BITS-1:0] view_scale = 31'd1073742;
  longint center_re = 0;
  longint center_im = 0;
  logic [DIM_BITS-1:0] res_x = 13'd800;
  logic [DIM_BITS-1:0] res_y = 13'd600;
  logic [DIM_BITS-1:0] size_x = 13'd800;
  logic [DIM_BITS-1:0] size_y = 13'd600;

  point_t pending_points[$];
  answer_t in_set_due[$];
  int unsigned send_idle_pct = 30;
  int unsigned points_queued = 0;
  int unsigned points_sent = 0;
  int unsigned results_seen = 0;
  int unsigned in_set_count = 0;
  int unsigned settings_used = 1;
  int unsigned errors = 0;
  int unsigned stall_cycles = 0;

  mandelbrot_membership_test dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .point_x  (point_x),
    .point_y  (point_y),
    .done     (done),
    .in_set   (in_set),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp_word(input longint v);
    if (v > WORD_TOP) begin
      return WORD_TOP;
    end
    if (v < -WORD_TOP - 1) begin
      return -WORD_TOP - 1;
    end
    return v;
  endfunction

  function automatic longint map_axis(input logic [COORD_BITS-1:0] p,
                                      input logic [DIM_BITS-1:0] res,
                                      input logic [DIM_BITS-1:0] sz,
                                      input longint ctr);
    longint unsigned num;
    longint unsigned den;
    longint unsigned q;
    den = (sz == 0) ? 64'd1 : 64'(sz);
    num = 64'(view_scale) * 64'(p) * 64'(res);
    q = num / den;
    return clamp_word(longint'(q) - ctr);
  endfunction

  function automatic bit predict_in_set(input logic [COORD_BITS-1:0] px,
                                        input logic [COORD_BITS-1:0] py);
    longint c_re;
    longint c_im;
    longint z_re;
    longint z_im;
    longint n_re;
    longint n_im;
    bit [63:0] sq_re;
    bit [63:0] sq_im;
    int unsigned passes;
    c_re = map_axis(px, res_x, size_x, center_re);
    c_im = map_axis(py, res_y, size_y, center_im);
    z_re = 0;
    z_im = 0;
    passes = 0;
    forever begin
      sq_re = z_re * z_re;
      sq_im = z_im * z_im;
      if (sq_re + sq_im >= ESCAPE_LIMIT) break;
      passes++;
      if (passes >= iter_limit) break;
      n_re = longint'(sq_re >> FRAC_BITS) - longint'(sq_im >> FRAC_BITS) + c_re;
      n_im = ((z_re * z_im) >>> (FRAC_BITS - 1)) + c_im;
      z_re = clamp_word(n_re);
      z_im = clamp_word(n_im);
    end
    return passes == iter_limit;
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= REPORT_CAP) begin
      $display("[%0t] MISMATCH: %s", $time, what);
    end
  endtask

  // The register is written at the edge after the one that raises wr_en.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] data);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    case (idx)
      CFG_MAX_ITER:  iter_limit = data[ITER_BITS-1:0];
      CFG_SCALE:     view_scale = data[SCALE_BITS-1:0];
      CFG_CENTER_RE: center_re = longint'(signed'(data));
      CFG_CENTER_IM: center_im = longint'(signed'(data));
      CFG_RES_X:     res_x = data[DIM_BITS-1:0];
      CFG_RES_Y:     res_y = data[DIM_BITS-1:0];
      CFG_SIZE_X:    size_x = data[DIM_BITS-1:0];
      CFG_SIZE_Y:    size_y = data[DIM_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic queue_point(input int unsigned x, input int unsigned y, input bit hold);
    point_t p;
    p.x = x[COORD_BITS-1:0];
    p.y = y[COORD_BITS-1:0];
    p.hold = hold;
    pending_points.push_back(p);
    points_queued++;
  endtask

  // Returns once every queued point has been answered and the block is free.
  task automatic wait_idle();
    do @(posedge clk);
    while (results_seen < points_queued || busy);
  endtask

  function automatic logic [31:0] junk_above(input logic [31:0] value, input int bits);
    logic [31:0] mask;
    mask = (bits >= 32) ? '1 : ((32'd1 << bits) - 32'd1);
    return ($urandom() & ~mask) | (value & mask);
  endfunction

  function automatic logic [31:0] pick_center(input logic [31:0] typical);
    case ($urandom_range(9))
      0: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      1: return $urandom();
      default: return typical + $urandom_range(32'h0800_0000) - 32'h0400_0000;
    endcase
  endfunction

  function automatic logic [DIM_BITS-1:0] corner_dim();
    case ($urandom_range(3))
      0: return 13'd0;
      1: return 13'd1;
      2: return 13'd4096;
      default: return 13'd8191;
    endcase
  endfunction

  task automatic pick_view();
    logic [ITER_BITS-1:0] lim;
    logic [SCALE_BITS-1:0] scl;
    logic [DIM_BITS-1:0] rx;
    logic [DIM_BITS-1:0] ry;
    logic [DIM_BITS-1:0] sx;
    logic [DIM_BITS-1:0] sy;
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) lim = ITER_BITS'($urandom_range(1));
    else if (pick == 1) lim = ITER_BITS'($urandom_range(300, 100));
    else lim = ITER_BITS'($urandom_range(64, 2));
    pick = $urandom_range(9);
    if (pick == 0) scl = $urandom_range(1) ? 31'h7FFF_FFFF : 31'd1;
    else if (pick == 1) scl = SCALE_BITS'($urandom());
    else scl = SCALE_BITS'($urandom_range(3_000_000, 300_000));
    pick = $urandom_range(9);
    if (pick == 0) begin
      rx = corner_dim();
      ry = corner_dim();
      sx = corner_dim();
      sy = corner_dim();
    end else if (pick <= 2) begin
      rx = DIM_BITS'($urandom());
      ry = DIM_BITS'($urandom());
      sx = DIM_BITS'($urandom());
      sy = DIM_BITS'($urandom());
    end else begin
      rx = DIM_BITS'($urandom_range(1024, 64));
      ry = DIM_BITS'($urandom_range(1024, 64));
      sx = rx;
      sy = ry;
    end
    write_reg(CFG_MAX_ITER, junk_above(32'(lim), ITER_BITS));
    write_reg(CFG_SCALE, junk_above(32'(scl), SCALE_BITS));
    write_reg(CFG_CENTER_RE, pick_center(32'h2000_0000));
    write_reg(CFG_CENTER_IM, pick_center(32'h1000_0000));
    write_reg(CFG_RES_X, junk_above(32'(rx), DIM_BITS));
    write_reg(CFG_RES_Y, junk_above(32'(ry), DIM_BITS));
    write_reg(CFG_SIZE_X, junk_above(32'(sx), DIM_BITS));
    write_reg(CFG_SIZE_Y, junk_above(32'(sy), DIM_BITS));
    settings_used++;
  endtask

  task automatic queue_random_points(input int n);
    int unsigned x;
    int unsigned y;
    for (int i = 0; i < n; i++) begin
      x = ($urandom_range(9) < 3) ? $urandom_range(4095) : $urandom_range(1023);
      y = ($urandom_range(9) < 3) ? $urandom_range(4095) : $urandom_range(1023);
      queue_point(x, y, $urandom_range(24) == 0);
    end
  endtask

  // Driver: a word stays on the ports until start meets a low busy.
  always @(posedge clk) begin : driver
    point_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        in_set_due.push_back('{x: point_x, y: point_y,
                               in_set: predict_in_set(point_x, point_y)});
        points_sent++;
      end
      if (!start || !busy) begin
        if (pending_points.size() != 0 && $urandom_range(99) >= send_idle_pct &&
            !(pending_points[0].hold && in_set_due.size() != 0)) begin
          nxt = pending_points.pop_front();
          start <= 1'b1;
          point_x <= nxt.x;
          point_y <= nxt.y;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: each answer is valid for the single cycle that done marks.
  always @(posedge clk) begin : monitor
    answer_t want;
    if (!rst && done === 1'b1) begin
      results_seen++;
      if (in_set === 1'b1) in_set_count++;
      if (in_set_due.size() == 0) begin
        report_mismatch($sformatf("answer in_set=%b with no point outstanding", in_set));
      end else begin
        want = in_set_due.pop_front();
        if (in_set !== want.in_set) begin
          report_mismatch($sformatf("point (%0d,%0d): in_set=%b, predicted %b",
                                    want.x, want.y, in_set, want.in_set));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a word moving", stall_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset view: origin, the four corners and alternating bit patterns.
    queue_point(0, 0, 1'b0);
    queue_point(4095, 4095, 1'b0);
    queue_point(4095, 0, 1'b0);
    queue_point(0, 4095, 1'b0);
    queue_point(12'hAAA, 12'h555, 1'b0);
    queue_point(12'h555, 12'hAAA, 1'b1);
    wait_idle();

    // Classic view spanning about -2..1 by -1..1.25.
    write_reg(CFG_MAX_ITER, 32'd64);
    write_reg(CFG_SCALE, 32'd1006633);
    write_reg(CFG_CENTER_RE, 32'h2000_0000);
    write_reg(CFG_CENTER_IM, 32'h1000_0000);
    write_reg(CFG_RES_X, 32'd800);
    write_reg(CFG_RES_Y, 32'd600);
    write_reg(CFG_SIZE_X, 32'd800);
    write_reg(CFG_SIZE_Y, 32'd600);
    settings_used++;
    queue_point(533, 266, 1'b0);
    queue_point(0, 266, 1'b0);
    queue_point(400, 300, 1'b0);
    queue_point(800, 600, 1'b0);
    queue_point(0, 0, 1'b0);
    wait_idle();

    // Zero sizes act as one, and a limit of one always lands inside the set.
    write_reg(CFG_SIZE_X, 32'hFFFF_E000);
    write_reg(CFG_SIZE_Y, 32'h0000_2000);
    write_reg(CFG_RES_X, 32'd1);
    write_reg(CFG_RES_Y, 32'd1);
    write_reg(CFG_MAX_ITER, 32'h1234_0001);
    settings_used++;
    queue_point(4095, 4095, 1'b0);
    queue_point(7, 9, 1'b0);
    wait_idle();

    // A zero limit never lands inside the set.
    write_reg(CFG_MAX_ITER, 32'hABCD_0000);
    settings_used++;
    queue_point(0, 0, 1'b0);
    queue_point(4095, 4095, 1'b0);
    wait_idle();

    // Largest limit and scale with the centers at their extremes.
    write_reg(CFG_MAX_ITER, 32'hFFFF_FFFF);
    write_reg(CFG_SCALE, 32'hFFFF_FFFF);
    write_reg(CFG_CENTER_RE, 32'h8000_0000);
    write_reg(CFG_CENTER_IM, 32'h7FFF_FFFF);
    write_reg(CFG_RES_X, 32'd4096);
    write_reg(CFG_SIZE_X, 32'd1);
    write_reg(CFG_RES_Y, 32'd1);
    write_reg(CFG_SIZE_Y, 32'd4096);
    settings_used++;
    queue_point(4095, 0, 1'b0);
    queue_point(0, 4095, 1'b0);
    wait_idle();

    // One point at the origin that runs the full 65535-pass limit.
    write_reg(CFG_SCALE, 32'h8000_0001);
    write_reg(CFG_CENTER_RE, 32'd0);
    write_reg(CFG_CENTER_IM, 32'd0);
    write_reg(CFG_RES_X, 32'd1);
    write_reg(CFG_SIZE_X, 32'd1);
    settings_used++;
    queue_point(0, 0, 1'b0);
    wait_idle();

    for (int phase = 0; phase < 12; phase++) begin
      send_idle_pct = (phase < 4) ? 30 : (phase < 8) ? 59 : 0;
      pick_view();
      queue_random_points(100);
      wait_idle();
    end

    repeat (600) @(posedge clk);
    if (in_set_due.size() != 0) begin
      report_mismatch($sformatf("%0d predicted answers never arrived", in_set_due.size()));
    end
    $display("Sent %0d points under %0d register settings; %0d of %0d answers were in the set.",
             points_sent, settings_used, in_set_count, results_seen);
    $display("Limits ranged from zero to 65535, sizes from zero to 8191, with wide writes.");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
